>>> hdl/mac_address_learning_table_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef MAC_ADDRESS_LEARNING_TABLE_UNIT_MACROS_SVH
`define MAC_ADDRESS_LEARNING_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define MLT_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLT_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mlt_pkg.sv
`default_nettype none

package mlt_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int ADDR_W = 48;
  localparam int CALL_W = 64;
  localparam int STATUS_W = 3;
  localparam int PRESET_COUNT = 3;

  localparam logic [ADDR_W-1:0] ADDR_BROADCAST = 48'hFFFF_FFFF_FFFF;
  localparam logic [ADDR_W-1:0] ADDR_ALL_HOSTS = 48'h0100_5E00_0001;
  localparam logic [ADDR_W-1:0] ADDR_DX = 48'h0100_5E00_0023;
  localparam logic [CALL_W-1:0] CALL_SPACES = 64'h2020_2020_2020_2020;
  localparam logic [CALL_W-1:0] CALL_CQ = 64'h4351_4351_4351_2020;

  localparam logic [1:0] PRESET_BROADCAST = 2'd0;
  localparam logic [1:0] PRESET_ALL_HOSTS = 2'd1;
  localparam logic [1:0] PRESET_DX = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_LEARNED = 3'd0,
    STATUS_KNOWN   = 3'd1,
    STATUS_FULL    = 3'd2,
    STATUS_FOUND   = 3'd3,
    STATUS_MISSING = 3'd4
  } status_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
    logic load;
  } mlt_cmd_t;

  typedef struct packed {
    logic done;
  } mlt_sts_t;

  function automatic logic [ADDR_W-1:0] preset_address(logic [1:0] idx);
    logic [ADDR_W-1:0] a;
    case (idx)
      PRESET_BROADCAST: a = ADDR_BROADCAST;
      PRESET_ALL_HOSTS: a = ADDR_ALL_HOSTS;
      PRESET_DX:        a = ADDR_DX;
      default:          a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [CALL_W-1:0] preset_call(logic [1:0] idx);
    logic [CALL_W-1:0] c;
    case (idx)
      PRESET_BROADCAST: c = CALL_SPACES;
      PRESET_ALL_HOSTS: c = CALL_CQ;
      PRESET_DX:        c = CALL_CQ;
      default:          c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mlt_if.sv
`default_nettype none

interface mlt_req_if import mlt_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] mac_address;
  logic [CALL_W-1:0] station_call;

  modport source (output valid, output op, output mac_address, output station_call,
                  input ready);
  modport sink (input valid, input op, input mac_address, input station_call,
                output ready);
endinterface

interface mlt_rsp_if import mlt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CALL_W-1:0]   found_call;

  modport source (output valid, output status, output found_call, input ready);
  modport sink (input valid, input status, input found_call, output ready);
endinterface

`default_nettype wire

>>> hdl/mlt_ram.sv
`default_nettype none

module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hdl/mlt_ctrl.sv
`default_nettype none

module mlt_ctrl import mlt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  mlt_sts_t sts,
  output mlt_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.done) begin
          cmd.commit = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign req_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/mlt_dp.sv
`default_nettype none

module mlt_dp import mlt_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  mlt_cmd_t            cmd,
  output mlt_sts_t            sts,
  input  logic                req_op,
  input  logic [ADDR_W-1:0]   req_mac_address,
  input  logic [CALL_W-1:0]   req_station_call,
  output logic [STATUS_W-1:0] rsp_status,
  output logic [CALL_W-1:0]   rsp_found_call
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = ADDR_W + CALL_W;

  logic              op;
  logic [ADDR_W-1:0] addr;
  logic [CALL_W-1:0] call;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     cmp_idx;
  logic              cmp_vld;
  logic [CW-1:0]     count;
  status_t           res_status;
  logic [CALL_W-1:0] res_call;

  logic [EW-1:0]     rd_data;
  logic [ADDR_W-1:0] entry_addr;
  logic [CALL_W-1:0] entry_call;
  logic              hit;
  logic              last;
  logic              full;
  logic              wr_en;

  mlt_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[IW-1:0]),
    .wr_data({addr, call}),
    .rd_addr(rd_idx),
    .rd_data(rd_data)
  );

  // The preloaded entries are never overwritten, so they come from constants.
  always_comb begin
    if (cmp_idx < IW'(PRESET_COUNT)) begin
      entry_addr = preset_address(cmp_idx[1:0]);
      entry_call = preset_call(cmp_idx[1:0]);
    end else begin
      entry_addr = rd_data[EW-1:CALL_W];
      entry_call = rd_data[CALL_W-1:0];
    end
  end

  assign hit = cmp_vld && (entry_addr == addr);
  assign last = cmp_vld && (CW'(cmp_idx) == count - CW'(1));
  assign full = (count == CW'(TABLE_DEPTH));
  assign sts.done = hit || last;
  assign wr_en = cmd.commit && !op && !hit && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(PRESET_COUNT);
      cmp_vld <= 1'b0;
    end else begin
      if (cmd.start || cmd.commit) begin
        cmp_vld <= 1'b0;
      end else if (cmd.scan) begin
        cmp_vld <= 1'b1;
      end
      if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= req_op;
      addr <= req_mac_address;
      call <= req_station_call;
      rd_idx <= '0;
    end
    if (cmd.scan) begin
      rd_idx <= rd_idx + IW'(1);
      cmp_idx <= rd_idx;
    end
    if (cmd.commit) begin
      if (op && hit) begin
        res_call <= entry_call;
      end else begin
        res_call <= '0;
      end
      if (op) begin
        if (hit) begin
          res_status <= STATUS_FOUND;
        end else begin
          res_status <= STATUS_MISSING;
        end
      end else if (hit) begin
        res_status <= STATUS_KNOWN;
      end else if (full) begin
        res_status <= STATUS_FULL;
      end else begin
        res_status <= STATUS_LEARNED;
      end
    end
    if (cmd.load) begin
      rsp_status <= res_status;
      rsp_found_call <= res_call;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mac_address_learning_table_unit.sv
// Learning table of Ethernet addresses with 8-character callsigns, TABLE_DEPTH
// entries, three of which (broadcast, all-hosts and DX multicast) are present
// after reset. A learn word adds its address in the next free slot unless it
// is already present or the table is full, and a lookup word returns the
// callsign of the first matching entry. Learned entries live in a single
// memory with one read port, the preset ones in constants, and are compared
// one per cycle. A new word is accepted only once the search of the previous
// one is over. The result is held in an output register, so the next word
// can be accepted while it waits.
`default_nettype none

module mac_address_learning_table_unit import mlt_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  mlt_req_if.sink    req,
  mlt_rsp_if.source  rsp
);

  mlt_cmd_t cmd;
  mlt_sts_t sts;

  mlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req.valid),
    .req_ready(req.ready),
    .rsp_valid(rsp.valid),
    .rsp_ready(rsp.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mlt_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_op          (req.op),
    .req_mac_address (req.mac_address),
    .req_station_call(req.station_call),
    .rsp_status      (rsp.status),
    .rsp_found_call  (rsp.found_call)
  );

endmodule

`default_nettype wire

>>> hdl/mlt_checker.sv
`default_nettype none
`include "mac_address_learning_table_unit_macros.svh"

module mlt_checker import mlt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] rsp_status,
  input logic [CALL_W-1:0]   rsp_found_call
);

  `MLT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_call), "stalled result word changed")
  `MLT_ASSERT_NOW(a_status_legal, clk, rst, rsp_valid, rsp_status <= STATUS_MISSING, "illegal status code")
  `MLT_ASSERT_NOW(a_call_zero, clk, rst, rsp_valid && rsp_status != STATUS_FOUND, rsp_found_call == '0, "callsign present without a match")
  `MLT_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready, "request taken while a search is running")

endmodule

bind mac_address_learning_table_unit mlt_checker u_mlt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_found_call(rsp.found_call)
);

`default_nettype wire
